/* hw/rtl/rds_pkg.sv */
// Shared types, widths and register codes of the reaction-diffusion stencil step.
package rds_pkg;

  // Fixed-point format of every concentration and coefficient.
  localparam int VALUE_W   = 24;
  localparam int FRAC_BITS = 20;

  // Field and port widths.
  localparam int GRID_W      = 11;
  localparam int CELL_W      = 10;
  localparam int CFG_IDX_W   = 3;
  localparam int CFG_DATA_W  = 24;
  localparam int IN_TDATA_W  = ((2 * VALUE_W + 7) / 8) * 8;
  localparam int OUT_FIELD_W = 2 * VALUE_W + 2 * CELL_W;
  localparam int OUT_TDATA_W = ((OUT_FIELD_W + 7) / 8) * 8;

  // The Laplacian of eight neighbours minus eight times the centre needs four guard bits.
  localparam int LAP_W = VALUE_W + 4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_GRID_ROWS    = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_GRID_COLUMNS = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_FEED         = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_KILL         = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_U  = 3'd4;
  localparam logic [CFG_IDX_W-1:0] REG_DIFFUSION_V  = 3'd5;
  localparam logic [CFG_IDX_W-1:0] REG_TIME_STEP    = 3'd6;

  // Register values after reset.
  localparam logic [GRID_W-1:0]  GRID_ROWS_RESET    = 11'd1024;
  localparam logic [GRID_W-1:0]  GRID_COLUMNS_RESET = 11'd1024;
  localparam logic [VALUE_W-1:0] FEED_RESET         = 24'd14680;
  localparam logic [VALUE_W-1:0] KILL_RESET         = 24'd56623;
  localparam logic [VALUE_W-1:0] DIFFUSION_U_RESET  = 24'd104858;
  localparam logic [VALUE_W-1:0] DIFFUSION_V_RESET  = 24'd52429;
  localparam logic [VALUE_W-1:0] TIME_STEP_RESET    = 24'd1048576;

  // Model coefficients, all signed Q4.20.
  typedef struct packed {
    logic [VALUE_W-1:0] feed;
    logic [VALUE_W-1:0] kill;
    logic [VALUE_W-1:0] diff_u;
    logic [VALUE_W-1:0] diff_v;
    logic [VALUE_W-1:0] dt;
  } coeff_t;

  // What travels with an interior cell down the update pipeline.
  typedef struct packed {
    logic [CELL_W-1:0]  row;
    logic [CELL_W-1:0]  col;
    logic               last;
    logic [VALUE_W-1:0] u;
    logic [VALUE_W-1:0] v;
  } cell_tag_t;

endpackage

/* hw/rtl/rds_update.sv */
// Pipelined Gray-Scott update of one interior cell from its centre values and Laplacians.
module rds_update
  import rds_pkg::*;
(
  input  logic               clk,
  input  logic               rst,
  input  logic               adv,
  input  coeff_t             coeff,
  input  logic               in_valid,
  input  cell_tag_t          in_tag,
  input  logic [LAP_W-1:0]   in_lap_u,
  input  logic [LAP_W-1:0]   in_lap_v,
  output logic               out_valid,
  output cell_tag_t          out_tag,
  output logic [VALUE_W-1:0] out_u,
  output logic [VALUE_W-1:0] out_v
);

  localparam int OMU_W   = VALUE_W + 1;
  localparam int PUV_W   = 2 * VALUE_W;
  localparam int PLAP_W  = VALUE_W + LAP_W;
  localparam int PLIN_W  = VALUE_W + OMU_W;
  localparam int UV_W    = PUV_W + 1 - FRAC_BITS;
  localparam int UVV_W   = UV_W + VALUE_W;
  localparam int SUM_W   = VALUE_W + LAP_W + 2;
  localparam int D_W     = SUM_W + 1 - FRAC_BITS;
  localparam int MU_W    = D_W + VALUE_W;
  localparam int STEP_W  = MU_W + 1 - FRAC_BITS;
  localparam int NEW_W   = STEP_W + 1;
  localparam int ONE     = 1 << FRAC_BITS;
  localparam int HALF    = 1 << (FRAC_BITS - 1);
  localparam int VAL_MAX = (1 << (VALUE_W - 1)) - 1;
  localparam int VAL_MIN = -(1 << (VALUE_W - 1));

  function automatic logic [VALUE_W-1:0] sat_value(input logic signed [NEW_W-1:0] x);
    logic [VALUE_W-1:0] res;
    if (x > NEW_W'(VAL_MAX)) begin
      res = VALUE_W'(VAL_MAX);
    end else if (x < NEW_W'(VAL_MIN)) begin
      res = VALUE_W'(VAL_MIN);
    end else begin
      res = x[VALUE_W-1:0];
    end
    return res;
  endfunction

  // Stage A: the five independent products.
  logic signed [OMU_W-1:0]  one_minus_u;
  logic signed [OMU_W-1:0]  feed_kill;
  logic                     a_valid;
  cell_tag_t                a_tag;
  logic signed [PUV_W-1:0]  a_puv;
  logic signed [PLAP_W-1:0] a_plu;
  logic signed [PLAP_W-1:0] a_plv;
  logic signed [PLIN_W-1:0] a_pfu;
  logic signed [PLIN_W-1:0] a_pkv;

  assign one_minus_u = OMU_W'(ONE) - OMU_W'($signed(in_tag.u));
  assign feed_kill   = OMU_W'($signed(coeff.feed)) + OMU_W'($signed(coeff.kill));

  always_ff @(posedge clk) begin
    if (rst) begin
      a_valid <= 1'b0;
    end else if (adv) begin
      a_valid <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      a_tag <= in_tag;
      a_puv <= $signed(in_tag.u) * $signed(in_tag.v);
      a_plu <= $signed(coeff.diff_u) * $signed(in_lap_u);
      a_plv <= $signed(coeff.diff_v) * $signed(in_lap_v);
      a_pfu <= $signed(coeff.feed) * one_minus_u;
      a_pkv <= feed_kill * $signed(in_tag.v);
    end
  end

  // Stage B: round u*v, multiply by v again, and gather the other terms.
  logic signed [PUV_W:0]    uv_biased;
  logic signed [UV_W-1:0]   uv;
  logic                     b_valid;
  cell_tag_t                b_tag;
  logic signed [UVV_W-1:0]  b_uvv;
  logic signed [SUM_W-1:0]  b_su;
  logic signed [SUM_W-1:0]  b_sv;

  assign uv_biased = $signed({a_puv[PUV_W-1], a_puv}) + (PUV_W + 1)'(HALF);
  assign uv        = $signed(uv_biased[PUV_W:FRAC_BITS]);

  always_ff @(posedge clk) begin
    if (rst) begin
      b_valid <= 1'b0;
    end else if (adv) begin
      b_valid <= a_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      b_tag <= a_tag;
      b_uvv <= uv * $signed(a_tag.v);
      b_su  <= SUM_W'(a_plu) + SUM_W'(a_pfu);
      b_sv  <= SUM_W'(a_plv) - SUM_W'(a_pkv);
    end
  end

  // Stage C: complete both rates of change and round them to Q.20.
  logic signed [SUM_W-1:0] sum_u;
  logic signed [SUM_W-1:0] sum_v;
  logic signed [SUM_W:0]   du_biased;
  logic signed [SUM_W:0]   dv_biased;
  logic                    c_valid;
  cell_tag_t               c_tag;
  logic signed [D_W-1:0]   c_du;
  logic signed [D_W-1:0]   c_dv;

  assign sum_u     = b_su - SUM_W'(b_uvv);
  assign sum_v     = b_sv + SUM_W'(b_uvv);
  assign du_biased = $signed({sum_u[SUM_W-1], sum_u}) + (SUM_W + 1)'(HALF);
  assign dv_biased = $signed({sum_v[SUM_W-1], sum_v}) + (SUM_W + 1)'(HALF);

  always_ff @(posedge clk) begin
    if (rst) begin
      c_valid <= 1'b0;
    end else if (adv) begin
      c_valid <= b_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      c_tag <= b_tag;
      c_du  <= $signed(du_biased[SUM_W:FRAC_BITS]);
      c_dv  <= $signed(dv_biased[SUM_W:FRAC_BITS]);
    end
  end

  // Stage D: scale by the time step.
  logic                   d_valid;
  cell_tag_t              d_tag;
  logic signed [MU_W-1:0] d_mu;
  logic signed [MU_W-1:0] d_mv;

  always_ff @(posedge clk) begin
    if (rst) begin
      d_valid <= 1'b0;
    end else if (adv) begin
      d_valid <= c_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      d_tag <= c_tag;
      d_mu  <= c_du * $signed(coeff.dt);
      d_mv  <= c_dv * $signed(coeff.dt);
    end
  end

  // Stage E: round the step, add it to the old value and saturate into the output register.
  logic signed [MU_W:0]    mu_biased;
  logic signed [MU_W:0]    mv_biased;
  logic signed [NEW_W-1:0] u_new;
  logic signed [NEW_W-1:0] v_new;

  assign mu_biased = $signed({d_mu[MU_W-1], d_mu}) + (MU_W + 1)'(HALF);
  assign mv_biased = $signed({d_mv[MU_W-1], d_mv}) + (MU_W + 1)'(HALF);
  assign u_new = NEW_W'($signed(mu_biased[MU_W:FRAC_BITS])) + NEW_W'($signed(d_tag.u));
  assign v_new = NEW_W'($signed(mv_biased[MU_W:FRAC_BITS])) + NEW_W'($signed(d_tag.v));

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (adv) begin
      out_valid <= d_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_tag <= d_tag;
      out_u   <= sat_value(u_new);
      out_v   <= sat_value(v_new);
    end
  end

endmodule

/* hw/rtl/reaction_diffusion_stencil_step.sv */
// Top level of the streaming 3x3 Gray-Scott reaction-diffusion update.
//
// Cells of a grid that includes a one-cell halo arrive on the s_axis channel in raster
// order, one (u, v) word per cell. Each interior cell leaves on the m_axis channel with
// its updated u and v, its row and column, and tlast on the last interior cell of the
// frame; halo cells only feed their neighbours and produce no output word.
// The grid size, the four rate coefficients and the time step are written on the cfg port,
// by the user only while the block is idle (the block does not enforce this); sizes outside
// the supported range are clamped.
// Throughput is one cell per clock while the sink keeps tready high: the two line
// stores are each one memory with a registered read, read at the incoming column in
// the cycle a word is taken and written back at that same column when the pipeline next
// advances, and consecutive cells always address different columns. A result reaches
// m_axis through the line store read, the Laplacian stage and the five arithmetic stages
// of the update pipeline.
// The whole pipeline advances together: while a result waits on m_axis and tready is
// low, every stage holds and s_axis_tready is low; otherwise a new word is taken.
// Reset clears the position counters, the window, the pipeline valids and loads the
// default registers; the line stores need no clearing since rows above the first two
// are always written before they are read.
module reaction_diffusion_stencil_step
  import rds_pkg::*;
#(
  parameter int MAX_COLUMNS = 1024,
  parameter int MAX_ROWS    = 1024
) (
  input  logic                   clk,
  input  logic                   rst,
  // Configuration write port.
  input  logic                   cfg_write,
  input  logic [CFG_IDX_W-1:0]   cfg_index,
  input  logic [CFG_DATA_W-1:0]  cfg_data,
  // Input cells.
  input  logic                   s_axis_tvalid,
  output logic                   s_axis_tready,
  input  logic [IN_TDATA_W-1:0]  s_axis_tdata,   // u_value, v_value
  // Updated interior cells.
  output logic                   m_axis_tvalid,
  input  logic                   m_axis_tready,
  output logic [OUT_TDATA_W-1:0] m_axis_tdata,   // u_next, v_next, cell_row, cell_column
  output logic                   m_axis_tlast    // frame_last
);

  localparam int COL_W     = $clog2(MAX_COLUMNS);
  localparam int ROW_W     = $clog2(MAX_ROWS);
  localparam int COL_LIM_W = (COL_W + 1 > GRID_W) ? COL_W + 1 : GRID_W;
  localparam int ROW_LIM_W = (ROW_W + 1 > GRID_W) ? ROW_W + 1 : GRID_W;

  function automatic logic signed [LAP_W-1:0] to_lap(input logic [VALUE_W-1:0] x);
    return LAP_W'($signed(x));
  endfunction

  // ---------------------------------------------------------------------------
  // Configuration registers.
  // ---------------------------------------------------------------------------
  logic [GRID_W-1:0] grid_rows;
  logic [GRID_W-1:0] grid_columns;
  coeff_t            coeff;

  always_ff @(posedge clk) begin
    if (rst) begin
      grid_rows     <= GRID_ROWS_RESET;
      grid_columns  <= GRID_COLUMNS_RESET;
      coeff.feed    <= FEED_RESET;
      coeff.kill    <= KILL_RESET;
      coeff.diff_u  <= DIFFUSION_U_RESET;
      coeff.diff_v  <= DIFFUSION_V_RESET;
      coeff.dt      <= TIME_STEP_RESET;
    end else if (cfg_write) begin
      case (cfg_index)
        REG_GRID_ROWS:    grid_rows    <= cfg_data[GRID_W-1:0];
        REG_GRID_COLUMNS: grid_columns <= cfg_data[GRID_W-1:0];
        REG_FEED:         coeff.feed   <= cfg_data[VALUE_W-1:0];
        REG_KILL:         coeff.kill   <= cfg_data[VALUE_W-1:0];
        REG_DIFFUSION_U:  coeff.diff_u <= cfg_data[VALUE_W-1:0];
        REG_DIFFUSION_V:  coeff.diff_v <= cfg_data[VALUE_W-1:0];
        REG_TIME_STEP:    coeff.dt     <= cfg_data[VALUE_W-1:0];
        default: ;
      endcase
    end
  end

  // Clamp the grid size to what the line stores and counters support, and keep the
  // index of the last row and column.
  logic [COL_LIM_W-1:0] cols_ext;
  logic [COL_LIM_W-1:0] cols_clamped;
  logic [ROW_LIM_W-1:0] rows_ext;
  logic [ROW_LIM_W-1:0] rows_clamped;
  logic [COL_W-1:0]     last_col;
  logic [ROW_W-1:0]     last_row;

  always_comb begin
    cols_ext = COL_LIM_W'(grid_columns);
    if (cols_ext < COL_LIM_W'(3)) begin
      cols_clamped = COL_LIM_W'(3);
    end else if (cols_ext > COL_LIM_W'(MAX_COLUMNS)) begin
      cols_clamped = COL_LIM_W'(MAX_COLUMNS);
    end else begin
      cols_clamped = cols_ext;
    end
    rows_ext = ROW_LIM_W'(grid_rows);
    if (rows_ext < ROW_LIM_W'(3)) begin
      rows_clamped = ROW_LIM_W'(3);
    end else if (rows_ext > ROW_LIM_W'(MAX_ROWS)) begin
      rows_clamped = ROW_LIM_W'(MAX_ROWS);
    end else begin
      rows_clamped = rows_ext;
    end
    last_col = COL_W'(cols_clamped - COL_LIM_W'(1));
    last_row = ROW_W'(rows_clamped - ROW_LIM_W'(1));
  end

  // ---------------------------------------------------------------------------
  // Handshake and raster position.
  // ---------------------------------------------------------------------------
  logic             adv;
  logic             accept;
  logic [COL_W-1:0] col_pos;
  logic [ROW_W-1:0] row_pos;
  logic [COL_W-1:0] col_cur;
  logic [ROW_W-1:0] row_cur;

  assign adv           = !m_axis_tvalid || m_axis_tready;
  assign s_axis_tready = adv;
  assign accept        = s_axis_tvalid && adv;

  // A position left beyond a smaller, newly written grid restarts at zero.
  assign col_cur = (col_pos > last_col) ? '0 : col_pos;
  assign row_cur = (row_pos > last_row) ? '0 : row_pos;

  always_ff @(posedge clk) begin
    if (rst) begin
      col_pos <= '0;
      row_pos <= '0;
    end else if (accept) begin
      if (col_cur == last_col) begin
        col_pos <= '0;
        row_pos <= (row_cur == last_row) ? '0 : row_cur + ROW_W'(1);
      end else begin
        col_pos <= col_cur + COL_W'(1);
        row_pos <= row_cur;
      end
    end
  end

  // ---------------------------------------------------------------------------
  // Read stage: capture the word and read both line stores at its column.
  // Each entry holds the cell two rows up in the low half and one row up in the high half.
  // ---------------------------------------------------------------------------
  logic [2*VALUE_W-1:0] u_line_mem [MAX_COLUMNS];
  logic [2*VALUE_W-1:0] v_line_mem [MAX_COLUMNS];
  logic [2*VALUE_W-1:0] u_rd;
  logic [2*VALUE_W-1:0] v_rd;

  logic               s0_valid;
  logic [COL_W-1:0]   s0_addr;
  logic [VALUE_W-1:0] s0_u;
  logic [VALUE_W-1:0] s0_v;
  logic               s0_emit;
  logic [CELL_W-1:0]  s0_row;
  logic [CELL_W-1:0]  s0_col;
  logic               s0_last;

  always_ff @(posedge clk) begin
    if (rst) begin
      s0_valid <= 1'b0;
    end else if (adv) begin
      s0_valid <= accept;
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      s0_addr <= col_cur;
      s0_u    <= s_axis_tdata[VALUE_W-1:0];
      s0_v    <= s_axis_tdata[2*VALUE_W-1:VALUE_W];
      s0_emit <= (row_cur >= ROW_W'(2)) && (col_cur >= COL_W'(2));
      s0_row  <= CELL_W'(row_cur - ROW_W'(1));
      s0_col  <= CELL_W'(col_cur - COL_W'(1));
      s0_last <= (row_cur == last_row) && (col_cur == last_col);
    end
  end

  // ---------------------------------------------------------------------------
  // Window stage: form the new column, write it back, and take both Laplacians.
  // ---------------------------------------------------------------------------
  logic [VALUE_W-1:0] u_col [3];
  logic [VALUE_W-1:0] v_col [3];
  logic [VALUE_W-1:0] u_win [6];
  logic [VALUE_W-1:0] v_win [6];
  logic               line_wr;

  assign u_col[0] = u_rd[VALUE_W-1:0];
  assign u_col[1] = u_rd[2*VALUE_W-1:VALUE_W];
  assign u_col[2] = s0_u;
  assign v_col[0] = v_rd[VALUE_W-1:0];
  assign v_col[1] = v_rd[2*VALUE_W-1:VALUE_W];
  assign v_col[2] = s0_v;
  assign line_wr  = adv && s0_valid;

  // The column written back always differs from the column read in the same cycle.
  always_ff @(posedge clk) begin
    if (accept) begin
      u_rd <= u_line_mem[col_cur];
      v_rd <= v_line_mem[col_cur];
    end
    if (line_wr) begin
      u_line_mem[s0_addr] <= {u_col[2], u_col[1]};
      v_line_mem[s0_addr] <= {v_col[2], v_col[1]};
    end
  end

  // The window keeps the two previous columns: entries 0 to 2 two columns back, entries
  // 3 to 5 one column back, each from the top row down, so entry 4 is the centre cell.
  always_ff @(posedge clk) begin
    if (rst) begin
      for (int i = 0; i < 6; i++) begin
        u_win[i] <= '0;
        v_win[i] <= '0;
      end
    end else if (line_wr) begin
      for (int i = 0; i < 3; i++) begin
        u_win[i]     <= u_win[i + 3];
        v_win[i]     <= v_win[i + 3];
        u_win[i + 3] <= u_col[i];
        v_win[i + 3] <= v_col[i];
      end
    end
  end

  logic signed [LAP_W-1:0] lap_u;
  logic signed [LAP_W-1:0] lap_v;

  assign lap_u = to_lap(u_win[0]) + to_lap(u_win[1]) + to_lap(u_win[2]) + to_lap(u_win[3])
               + to_lap(u_win[5]) + to_lap(u_col[0]) + to_lap(u_col[1]) + to_lap(u_col[2])
               - (to_lap(u_win[4]) <<< 3);
  assign lap_v = to_lap(v_win[0]) + to_lap(v_win[1]) + to_lap(v_win[2]) + to_lap(v_win[3])
               + to_lap(v_win[5]) + to_lap(v_col[0]) + to_lap(v_col[1]) + to_lap(v_col[2])
               - (to_lap(v_win[4]) <<< 3);

  // Only interior cells go on into the update pipeline.
  logic             l_valid;
  cell_tag_t        l_tag;
  logic [LAP_W-1:0] l_lap_u;
  logic [LAP_W-1:0] l_lap_v;

  always_ff @(posedge clk) begin
    if (rst) begin
      l_valid <= 1'b0;
    end else if (adv) begin
      l_valid <= s0_valid && s0_emit;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      l_tag.row  <= s0_row;
      l_tag.col  <= s0_col;
      l_tag.last <= s0_last;
      l_tag.u    <= u_win[4];
      l_tag.v    <= v_win[4];
      l_lap_u    <= lap_u;
      l_lap_v    <= lap_v;
    end
  end

  // ---------------------------------------------------------------------------
  // Update pipeline; its last stage is the output register.
  // ---------------------------------------------------------------------------
  cell_tag_t          res_tag;
  logic [VALUE_W-1:0] res_u;
  logic [VALUE_W-1:0] res_v;

  rds_update u_update (
    .clk       (clk),
    .rst       (rst),
    .adv       (adv),
    .coeff     (coeff),
    .in_valid  (l_valid),
    .in_tag    (l_tag),
    .in_lap_u  (l_lap_u),
    .in_lap_v  (l_lap_v),
    .out_valid (m_axis_tvalid),
    .out_tag   (res_tag),
    .out_u     (res_u),
    .out_v     (res_v)
  );

  assign m_axis_tdata = {(OUT_TDATA_W - OUT_FIELD_W)'(0), res_tag.col, res_tag.row,
                         res_v, res_u};
  assign m_axis_tlast = res_tag.last;

endmodule

/* hw/rtl/rds_checker.sv */
// Port-level assertions for the reaction-diffusion stencil step, bound to its top level.
module rds_checker
  import rds_pkg::*;
(
  input logic                   clk,
  input logic                   rst,
  input logic                   s_axis_tready,
  input logic                   m_axis_tvalid,
  input logic                   m_axis_tready,
  input logic [OUT_TDATA_W-1:0] m_axis_tdata,
  input logic                   m_axis_tlast
);

  // A stalled output word stays put until it is taken.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |=>
      m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tlast))
    else $error("output word changed while stalled");

  // With the output register empty the block must be taking input.
  a_ready_when_empty: assert property (@(posedge clk) disable iff (rst)
    !m_axis_tvalid |-> s_axis_tready)
    else $error("input not ready while the output register is empty");

  // A stalled output freezes the whole pipeline, so no input word may enter.
  a_no_accept_on_stall: assert property (@(posedge clk) disable iff (rst)
    m_axis_tvalid && !m_axis_tready |-> !s_axis_tready)
    else $error("input taken while the output is stalled");

  // Nothing comes out in the cycle after a reset edge.
  a_quiet_after_reset: assert property (@(posedge clk)
    rst |=> !m_axis_tvalid)
    else $error("output valid straight after reset");

endmodule

bind reaction_diffusion_stencil_step rds_checker u_rds_checker (
  .clk           (clk),
  .rst           (rst),
  .s_axis_tready (s_axis_tready),
  .m_axis_tvalid (m_axis_tvalid),
  .m_axis_tready (m_axis_tready),
  .m_axis_tdata  (m_axis_tdata),
  .m_axis_tlast  (m_axis_tlast)
);
